FILE: src/servo_ramp_pwm_controller_macros.svh
// Assertion macros shared by the servo ramp PWM controller modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SERVO_RAMP_PWM_CONTROLLER_MACROS_SVH
`define SERVO_RAMP_PWM_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SRPC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SRPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/srpc_pkg.sv
// Package of the servo ramp PWM controller: types, codes and constants.
// Used by every other file of the block but the macro header; depends on nothing.
`default_nettype none

package srpc_pkg;

  // Channel count and field widths.
  localparam int NUM_CHANNELS = 6;
  localparam int CH_W         = 3;
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int POS_W        = 9;
  localparam int IVL_W        = 8;
  localparam int CMP_W        = 16;
  localparam int GAIN_W       = 8;
  localparam int POL_W        = 6;
  localparam int CFG_DATA_W   = 16;
  localparam int PROD_W       = POS_W + GAIN_W + 1;
  localparam int SUM_W        = PROD_W + 1;

  // Position limits in degrees.
  localparam int POS_MIN = -180;
  localparam int POS_MAX = 180;

  // Register reset values.
  localparam logic [CMP_W-1:0]  CENTER_RESET   = 16'd3010;
  localparam logic [GAIN_W-1:0] GAIN_RESET     = 8'd19;
  localparam logic [POL_W-1:0]  POLARITY_RESET = 6'd2;

  // Depth of the queue between front and back.
  localparam int Q_DEPTH = 2;

  typedef logic signed [POS_W-1:0] pos_t;

  // Request function codes.
  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_IMM  = 2'd1,
    FUNC_RAMP = 2'd2
  } func_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_CENTER   = 2'd0,
    CFG_GAIN     = 2'd1,
    CFG_POLARITY = 2'd2
  } cfg_idx_t;

  // One compare write handed from the front to the back.
  typedef struct packed {
    logic [CH_W-1:0] channel;
    pos_t            position;
    logic            final_write;
    logic            rejected;
  } job_t;

  // Live configuration seen by the back.
  typedef struct packed {
    logic [CMP_W-1:0]  center;
    logic [GAIN_W-1:0] gain;
    logic [POL_W-1:0]  polarity;
  } cfg_t;

  // Position of a channel after reset: channel 3 parks at 60 degrees.
  function automatic pos_t pos_reset_value(input int idx);
    pos_t v;
    v = '0;
    if (idx == 3) begin
      v = 9'sd60;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: src/srpc_channels.sv
// Handshake channel interfaces of the servo ramp PWM controller.
// Depends on srpc_pkg for field widths and the register index type.
`default_nettype none

// Request channel: ticks and moves.
interface srpc_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       func;
  logic [srpc_pkg::CH_W-1:0]        channel;
  logic signed [srpc_pkg::POS_W-1:0] target;
  logic [srpc_pkg::IVL_W-1:0]       interval;

  modport source (output valid, func, channel, target, interval, input ready);
  modport sink   (input valid, func, channel, target, interval, output ready);
endinterface

// Result channel: compare register writes.
interface srpc_out_if;
  logic                       valid;
  logic                       ready;
  logic [srpc_pkg::CH_W-1:0]  out_channel;
  logic [srpc_pkg::CMP_W-1:0] compare;
  logic                       final_write;
  logic                       rejected;

  modport source (output valid, out_channel, compare, final_write, rejected, input ready);
  modport sink   (input valid, out_channel, compare, final_write, rejected, output ready);
endinterface

// Configuration write channel.
interface srpc_cfg_if;
  logic                            valid;
  logic                            ready;
  srpc_pkg::cfg_idx_t              index;
  logic [srpc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/srpc_queue.sv
// Short queue of compare jobs between the front and the back.
// Depends on srpc_pkg for the job type and the queue depth.
`default_nettype none

module srpc_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire srpc_pkg::job_t push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output srpc_pkg::job_t      pop_data
);

  localparam int PTR_W = (srpc_pkg::Q_DEPTH > 1) ? $clog2(srpc_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(srpc_pkg::Q_DEPTH + 1);

  srpc_pkg::job_t   entries_r [srpc_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  // Handshake status.
  assign push_ready = (count_r != CNT_W'(srpc_pkg::Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count update, wrapping at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(srpc_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(srpc_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage carries no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: src/srpc_front.sv
// Front of the servo ramp PWM controller: takes requests, keeps channel
// positions and the ramp state, and queues one compare job per result.
// Depends on srpc_pkg, srpc_channels and the assertion macro header.
`default_nettype none

`include "servo_ramp_pwm_controller_macros.svh"

module srpc_front (
  input  wire logic      clk,
  input  wire logic      rst_n,
  srpc_in_if.sink        in_chan,
  output logic           push_valid,
  input  wire logic      push_ready,
  output srpc_pkg::job_t push_job
);

  // Channel positions and ramp state.
  srpc_pkg::pos_t               positions_r   [srpc_pkg::NUM_CHANNELS];
  srpc_pkg::pos_t               positions_nxt [srpc_pkg::NUM_CHANNELS];
  logic                         ramp_active_r, ramp_active_nxt;
  logic [srpc_pkg::CH_W-1:0]    ramp_ch_r, ramp_ch_nxt;
  srpc_pkg::pos_t               ramp_pos_r, ramp_pos_nxt;
  srpc_pkg::pos_t               ramp_tgt_r, ramp_tgt_nxt;
  logic [srpc_pkg::IVL_W-1:0]   countdown_r, countdown_nxt;
  logic [srpc_pkg::IVL_W-1:0]   step_interval_r, step_interval_nxt;

  logic                         accept;
  logic                         is_tick, is_move, ch_ok;
  srpc_pkg::pos_t               tgt_sat;
  srpc_pkg::pos_t               pos_cur;
  logic [srpc_pkg::IVL_W-1:0]   new_ivl;
  logic [srpc_pkg::CH_IDX_W-1:0] req_idx;
  logic                         do_step;
  logic [srpc_pkg::CH_W-1:0]    base_ch;
  srpc_pkg::pos_t               base_pos, base_tgt, step_pos;
  logic                         step_fin;

  // Requests are taken whenever the queue has room.
  assign in_chan.ready = push_ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // Request decode.
  assign is_tick = (in_chan.func == srpc_pkg::FUNC_TICK);
  assign is_move = (in_chan.func == srpc_pkg::FUNC_IMM) || (in_chan.func == srpc_pkg::FUNC_RAMP);
  assign ch_ok   = ({1'b0, in_chan.channel} < (srpc_pkg::CH_W + 1)'(srpc_pkg::NUM_CHANNELS));
  assign req_idx = in_chan.channel[srpc_pkg::CH_IDX_W-1:0];
  assign pos_cur = positions_r[req_idx];
  assign new_ivl = (in_chan.interval == '0) ? srpc_pkg::IVL_W'(1) : in_chan.interval;

  // Saturate the target to the position range.
  always_comb begin
    if (in_chan.target < srpc_pkg::POS_W'(srpc_pkg::POS_MIN)) begin
      tgt_sat = srpc_pkg::POS_W'(srpc_pkg::POS_MIN);
    end else if (in_chan.target > srpc_pkg::POS_W'(srpc_pkg::POS_MAX)) begin
      tgt_sat = srpc_pkg::POS_W'(srpc_pkg::POS_MAX);
    end else begin
      tgt_sat = in_chan.target;
    end
  end

  // One-degree step: a tick steps the running ramp, a ramped move starts one.
  assign base_ch  = is_tick ? ramp_ch_r  : in_chan.channel;
  assign base_pos = is_tick ? ramp_pos_r : pos_cur;
  assign base_tgt = is_tick ? ramp_tgt_r : tgt_sat;
  assign step_pos = (base_pos < base_tgt) ? base_pos + srpc_pkg::pos_t'(1)
                                          : base_pos - srpc_pkg::pos_t'(1);
  assign step_fin = (step_pos == base_tgt);

  // Request handling and next state.
  always_comb begin
    positions_nxt     = positions_r;
    ramp_active_nxt   = ramp_active_r;
    ramp_ch_nxt       = ramp_ch_r;
    ramp_pos_nxt      = ramp_pos_r;
    ramp_tgt_nxt      = ramp_tgt_r;
    countdown_nxt     = countdown_r;
    step_interval_nxt = step_interval_r;
    push_valid        = 1'b0;
    push_job          = '0;
    do_step           = 1'b0;

    if (accept) begin
      case (in_chan.func)
        srpc_pkg::FUNC_TICK: begin
          if (ramp_active_r) begin
            if (countdown_r > srpc_pkg::IVL_W'(1)) begin
              countdown_nxt = countdown_r - 1'b1;
            end else begin
              do_step = 1'b1;
            end
          end
        end
        srpc_pkg::FUNC_IMM: begin
          if (ch_ok) begin
            if (ramp_active_r) begin
              push_valid        = 1'b1;
              push_job.channel  = in_chan.channel;
              push_job.rejected = 1'b1;
            end else begin
              positions_nxt[req_idx] = tgt_sat;
              push_valid             = 1'b1;
              push_job.channel       = in_chan.channel;
              push_job.position      = tgt_sat;
              push_job.final_write   = 1'b1;
            end
          end
        end
        srpc_pkg::FUNC_RAMP: begin
          if (ch_ok) begin
            if (ramp_active_r) begin
              push_valid        = 1'b1;
              push_job.channel  = in_chan.channel;
              push_job.rejected = 1'b1;
            end else if (pos_cur != tgt_sat) begin
              ramp_active_nxt   = 1'b1;
              ramp_ch_nxt       = in_chan.channel;
              ramp_tgt_nxt      = tgt_sat;
              step_interval_nxt = new_ivl;
              do_step           = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase

      // A step writes one compare value and ends the ramp on reaching the target.
      if (do_step) begin
        push_valid           = 1'b1;
        push_job.channel     = base_ch;
        push_job.position    = step_pos;
        push_job.final_write = step_fin;
        ramp_pos_nxt         = step_pos;
        if (step_fin) begin
          ramp_active_nxt = 1'b0;
          countdown_nxt   = '0;
          positions_nxt[base_ch[srpc_pkg::CH_IDX_W-1:0]] = base_tgt;
        end else begin
          countdown_nxt = is_tick ? step_interval_r : new_ivl;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < srpc_pkg::NUM_CHANNELS; i++) begin
        positions_r[i] <= srpc_pkg::pos_reset_value(i);
      end
      ramp_active_r   <= 1'b0;
      ramp_ch_r       <= '0;
      ramp_pos_r      <= '0;
      ramp_tgt_r      <= '0;
      countdown_r     <= '0;
      step_interval_r <= srpc_pkg::IVL_W'(1);
    end else begin
      positions_r     <= positions_nxt;
      ramp_active_r   <= ramp_active_nxt;
      ramp_ch_r       <= ramp_ch_nxt;
      ramp_pos_r      <= ramp_pos_nxt;
      ramp_tgt_r      <= ramp_tgt_nxt;
      countdown_r     <= countdown_nxt;
      step_interval_r <= step_interval_nxt;
    end
  end

  // A running ramp has not yet reached its target.
  `SRPC_ASSERT_IMPLY(a_ramp_short_of_target, ramp_active_r, ramp_pos_r != ramp_tgt_r, "ramp active at target")
  // A running ramp always has a non-zero step interval.
  `SRPC_ASSERT_IMPLY(a_ramp_interval_set, ramp_active_r, step_interval_r != '0, "ramp interval is zero")
  // A move refused during a ramp leaves the ramp running.
  `SRPC_ASSERT_NEXT(a_refusal_keeps_ramp, accept && is_move && ch_ok && ramp_active_r, ramp_active_r, "refused move ended ramp")

endmodule

`default_nettype wire

FILE: src/srpc_back.sv
// Back of the servo ramp PWM controller: turns queued jobs into saturated
// compare values through a multiply stage and an output register.
// Depends on srpc_pkg and srpc_channels.
`default_nettype none

module srpc_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire srpc_pkg::cfg_t cfg,
  input  wire logic           job_valid,
  output logic                job_ready,
  input  wire srpc_pkg::job_t job,
  srpc_out_if.source          out_chan
);

  localparam int POL_EXT_W = 2 ** srpc_pkg::CH_W;

  // Multiply stage.
  logic                              s1_valid_r;
  srpc_pkg::job_t                    s1_job_r;
  logic signed [srpc_pkg::PROD_W-1:0] s1_prod_r;
  logic                              s1_add_r;

  // Output register.
  logic                       out_valid_r;
  logic [srpc_pkg::CH_W-1:0]  out_channel_r;
  logic [srpc_pkg::CMP_W-1:0] compare_r, compare_nxt;
  logic                       final_r;
  logic                       rejected_r;

  logic                              out_adv, s1_adv;
  logic signed [srpc_pkg::PROD_W-1:0] prod;
  logic [POL_EXT_W-1:0]              pol_ext;
  logic                              pol_add;
  logic signed [srpc_pkg::SUM_W-1:0] sum;

  // Elastic stage control.
  assign out_adv   = !out_valid_r || out_chan.ready;
  assign s1_adv    = !s1_valid_r || out_adv;
  assign job_ready = s1_adv;

  // Gain times position; channels beyond the mask read as subtracting.
  assign prod    = $signed({1'b0, cfg.gain}) * job.position;
  assign pol_ext = {(POL_EXT_W - srpc_pkg::POL_W)'(0), cfg.polarity};
  assign pol_add = pol_ext[job.channel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && job_valid) begin
      s1_job_r  <= job;
      s1_prod_r <= prod;
      s1_add_r  <= pol_add;
    end
  end

  // Centre plus or minus the product, clamped to the compare range; rejected jobs write zero.
  always_comb begin
    if (s1_add_r) begin
      sum = $signed({(srpc_pkg::SUM_W - srpc_pkg::CMP_W)'(0), cfg.center})
            + srpc_pkg::SUM_W'(s1_prod_r);
    end else begin
      sum = $signed({(srpc_pkg::SUM_W - srpc_pkg::CMP_W)'(0), cfg.center})
            - srpc_pkg::SUM_W'(s1_prod_r);
    end
    if (s1_job_r.rejected || (sum < 0)) begin
      compare_nxt = '0;
    end else if (sum > $signed(srpc_pkg::SUM_W'({srpc_pkg::CMP_W{1'b1}}))) begin
      compare_nxt = '1;
    end else begin
      compare_nxt = sum[srpc_pkg::CMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_channel_r <= s1_job_r.channel;
      compare_r     <= compare_nxt;
      final_r       <= s1_job_r.final_write;
      rejected_r    <= s1_job_r.rejected;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_channel = out_channel_r;
  assign out_chan.compare     = compare_r;
  assign out_chan.final_write = final_r;
  assign out_chan.rejected    = rejected_r;

endmodule

`default_nettype wire

FILE: src/servo_ramp_pwm_controller.sv
// Servo ramp PWM controller for six channels. Ticks and move requests are
// taken at one per clock whenever the two-entry job queue has room; the front
// updates channel positions and the ramp in the same cycle, so a request never
// waits on the one before it. Each result passes through the queue entry, the
// multiply stage and the output register before it is offered, and the output
// register lets new requests flow in while a result waits to be taken.
// Configuration writes are always accepted and should be made while no request
// is in flight.
// Depends on srpc_pkg, srpc_channels, srpc_queue, srpc_front and srpc_back.
`default_nettype none

module servo_ramp_pwm_controller (
  input  wire logic clk,
  input  wire logic rst_n,
  srpc_in_if.sink    in_chan,
  srpc_out_if.source out_chan,
  srpc_cfg_if.sink   cfg_chan
);

  srpc_pkg::cfg_t cfg_r, cfg_nxt;
  logic           q_push_valid, q_push_ready;
  srpc_pkg::job_t q_push_job;
  logic           q_pop_valid, q_pop_ready;
  srpc_pkg::job_t q_pop_job;

  // Configuration register writes.
  assign cfg_chan.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      case (cfg_chan.index)
        srpc_pkg::CFG_CENTER:   cfg_nxt.center   = cfg_chan.data[srpc_pkg::CMP_W-1:0];
        srpc_pkg::CFG_GAIN:     cfg_nxt.gain     = cfg_chan.data[srpc_pkg::GAIN_W-1:0];
        srpc_pkg::CFG_POLARITY: cfg_nxt.polarity = cfg_chan.data[srpc_pkg::POL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center   <= srpc_pkg::CENTER_RESET;
      cfg_r.gain     <= srpc_pkg::GAIN_RESET;
      cfg_r.polarity <= srpc_pkg::POLARITY_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Request front.
  srpc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_job   (q_push_job)
  );

  // Job queue between front and back.
  srpc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_job),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_job)
  );

  // Compare value back end.
  srpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (q_pop_valid),
    .job_ready (q_pop_ready),
    .job       (q_pop_job),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

FILE: bench/tb_servo_ramp_pwm_controller.sv
// Self-checking bench for the servo ramp PWM controller: directed requests, then random
// phases under several register settings, each write checked against predictor or script.
// Depends on srpc_pkg, the srpc channel interfaces and the controller RTL.
`default_nettype none

module tb_servo_ramp_pwm_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import srpc_pkg::*;

  // Function code the block does not use.
  localparam logic [1:0] FUNC_UNUSED    = 2'd3;
  localparam int         PARKED_CHANNEL = 3;
  localparam int         PARKED_DEGREES = 60;
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         HOLD_OFF_CYCLES = 300;
  localparam int         ITEMS_PER_PHASE = 270;
  localparam int         NUM_PHASES      = 6;

  typedef struct packed {
    logic [1:0]              func;
    logic [CH_W-1:0]         ch;
    logic signed [POS_W-1:0] target;
    logic [IVL_W-1:0]        interval;
  } request_t;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [CMP_W-1:0] compare;
    logic             final_write;
    logic             rejected;
  } pwm_write_t;

  typedef struct packed {
    request_t   req;
    logic       literal;
    pwm_write_t want;
  } script_row_t;

  localparam pwm_write_t NO_WRITE = '0;

  // Directed requests at the reset register values. Rows with literal set carry
  // a hand-worked compare write; the rest are left to the predictor.
  localparam script_row_t DIRECTED_SCRIPT [23] = '{
    '{'{FUNC_TICK,   3'd0, 9'sd0,   8'd1},   1'b0, NO_WRITE},
    '{'{FUNC_IMM,    3'd0, 9'sd0,   8'd1},   1'b1, '{3'd0, 16'd3010, 1'b1, 1'b0}},
    '{'{FUNC_IMM,    3'd1, 9'sd180, 8'd1},   1'b1, '{3'd1, 16'd6430, 1'b1, 1'b0}},
    '{'{FUNC_IMM,    3'd2, -9'sd180, 8'd1},  1'b1, '{3'd2, 16'd6430, 1'b1, 1'b0}},
    '{'{FUNC_IMM,    3'd4, 9'sd255, 8'd255}, 1'b1, '{3'd4, 16'd0,    1'b1, 1'b0}},
    '{'{FUNC_IMM,    3'd5, 9'h100,  8'd0},   1'b1, '{3'd5, 16'd6430, 1'b1, 1'b0}},
    '{'{FUNC_IMM,    3'd6, 9'sd10,  8'd1},   1'b0, NO_WRITE},
    '{'{FUNC_IMM,    3'd7, -9'sd1,  8'd1},   1'b0, NO_WRITE},
    '{'{FUNC_UNUSED, 3'd0, 9'sd20,  8'd1},   1'b0, NO_WRITE},
    '{'{FUNC_RAMP,   3'd1, 9'sd200, 8'd7},   1'b0, NO_WRITE},
    '{'{FUNC_RAMP,   3'd3, 9'sd62,  8'd0},   1'b0, NO_WRITE},
    '{'{FUNC_IMM,    3'd0, 9'sd5,   8'd1},   1'b1, '{3'd0, 16'd0, 1'b0, 1'b1}},
    '{'{FUNC_RAMP,   3'd5, 9'sd0,   8'd1},   1'b1, '{3'd5, 16'd0, 1'b0, 1'b1}},
    '{'{FUNC_RAMP,   3'd6, 9'sd0,   8'd1},   1'b0, NO_WRITE},
    '{'{FUNC_UNUSED, 3'd2, 9'sd0,   8'd1},   1'b0, NO_WRITE},
    '{'{FUNC_TICK,   3'd0, 9'sd0,   8'd1},   1'b0, NO_WRITE},
    '{'{FUNC_RAMP,   3'd0, -9'sd2,  8'd3},   1'b0, NO_WRITE},
    '{'{FUNC_TICK,   3'd0, 9'sd0,   8'd1},   1'b0, NO_WRITE},
    '{'{FUNC_TICK,   3'd0, 9'sd0,   8'd1},   1'b0, NO_WRITE},
    '{'{FUNC_TICK,   3'd0, 9'sd0,   8'd1},   1'b0, NO_WRITE},
    '{'{FUNC_RAMP,   3'd2, -9'sd179, 8'd255}, 1'b0, NO_WRITE},
    '{'{FUNC_TICK,   3'd0, 9'sd0,   8'd1},   1'b0, NO_WRITE},
    '{'{FUNC_RAMP,   3'd4, 9'sd179, 8'd1},   1'b0, NO_WRITE}
  };

  logic clk;
  logic rst_n;

  srpc_in_if  in_if ();
  srpc_out_if out_if ();
  srpc_cfg_if cfg_if ();

  servo_ramp_pwm_controller i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // Predictor state: registers, stored positions and the one running ramp.
  logic [CMP_W-1:0]  cur_center;
  logic [GAIN_W-1:0] cur_gain;
  logic [POL_W-1:0]  cur_polarity;
  int                servo_pos [8];
  bit                ramp_on;
  logic [CH_W-1:0]   ramp_ch;
  int                ramp_pos;
  int                ramp_goal;
  int                ticks_left;
  int                ticks_per_step;

  pwm_write_t pending_writes [$];
  int         mismatch_count;
  bit         quiet;
  bit         hold_off_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Generous overall limit on the run.
  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void reset_predictor();
    cur_center   = CENTER_RESET;
    cur_gain     = GAIN_RESET;
    cur_polarity = POLARITY_RESET;
    foreach (servo_pos[i]) servo_pos[i] = 0;
    servo_pos[PARKED_CHANNEL] = PARKED_DEGREES;
    ramp_on        = 1'b0;
    ramp_ch        = '0;
    ramp_pos       = 0;
    ramp_goal      = 0;
    ticks_left     = 0;
    ticks_per_step = 1;
  endfunction

  // Centre plus or minus gain times position, clamped to the compare range.
  function automatic logic [CMP_W-1:0] compare_for(logic [CH_W-1:0] ch, int pos);
    int  centre_val;
    int  gain_val;
    int  sum;
    bit  add;
    centre_val = cur_center;
    gain_val   = cur_gain;
    add        = 1'b0;
    if (ch < NUM_CHANNELS) add = cur_polarity[ch];
    sum = add ? centre_val + gain_val * pos : centre_val - gain_val * pos;
    if (sum < 0) sum = 0;
    if (sum > 65535) sum = 65535;
    return sum[CMP_W-1:0];
  endfunction

  // One degree toward the goal; the ramp ends on the step that reaches it.
  function automatic pwm_write_t ramp_advance();
    pwm_write_t w;
    if (ramp_pos < ramp_goal) ramp_pos++;
    else if (ramp_pos > ramp_goal) ramp_pos--;
    w = '{ramp_ch, compare_for(ramp_ch, ramp_pos), ramp_pos == ramp_goal, 1'b0};
    if (w.final_write) begin
      ramp_on = 1'b0;
      servo_pos[ramp_ch] = ramp_goal;
    end else begin
      ticks_left = ticks_per_step;
    end
    return w;
  endfunction

  // Updates the predictor for one accepted request; returns 1 when a write follows.
  function automatic bit predict_request(input request_t r, output pwm_write_t w);
    int tgt;
    w   = NO_WRITE;
    tgt = r.target;
    if (tgt < POS_MIN) tgt = POS_MIN;
    if (tgt > POS_MAX) tgt = POS_MAX;
    if (r.func == FUNC_TICK) begin
      if (!ramp_on) return 1'b0;
      if (ticks_left > 1) begin
        ticks_left--;
        return 1'b0;
      end
      ticks_left = 0;
      w = ramp_advance();
      return 1'b1;
    end
    if (r.func == FUNC_UNUSED || r.ch >= NUM_CHANNELS) return 1'b0;
    if (ramp_on) begin
      w = '{r.ch, 16'd0, 1'b0, 1'b1};
      return 1'b1;
    end
    if (r.func == FUNC_IMM) begin
      servo_pos[r.ch] = tgt;
      w = '{r.ch, compare_for(r.ch, tgt), 1'b1, 1'b0};
      return 1'b1;
    end
    if (servo_pos[r.ch] == tgt) return 1'b0;
    ramp_on        = 1'b1;
    ramp_ch        = r.ch;
    ramp_pos       = servo_pos[r.ch];
    ramp_goal      = tgt;
    ticks_per_step = (r.interval == 0) ? 1 : r.interval;
    w = ramp_advance();
    return 1'b1;
  endfunction

  // Mostly back to back, sometimes a short pause, now and then a long one.
  function automatic int idle_length();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random request shaped around the predictor state: while a ramp runs most
  // requests are ticks, otherwise moves dominate, some of them to nearby angles.
  function automatic request_t random_request(output bit counts);
    request_t r;
    int       pick;
    int       delta;
    r.func     = FUNC_TICK;
    r.ch       = $urandom_range(0, NUM_CHANNELS - 1);
    r.target   = $urandom_range(0, 511);
    r.interval = $urandom_range(0, 255);
    pick       = $urandom_range(0, 99);
    counts     = 1'b1;
    if (pick < 8) begin
      counts = 1'b0;
      if (pick < 4) begin
        r.func = FUNC_UNUSED;
      end else begin
        r.func = $urandom_range(FUNC_IMM, FUNC_RAMP);
        r.ch   = $urandom_range(NUM_CHANNELS, 7);
      end
    end else if (ramp_on) begin
      if (pick >= 88) r.func = $urandom_range(FUNC_IMM, FUNC_RAMP);
    end else if (pick < 20) begin
      counts = 1'b0;
    end else if (pick < 50) begin
      r.func = FUNC_IMM;
      if (pick < 35) r.target = $urandom_range(0, 360) - 180;
    end else begin
      r.func = FUNC_RAMP;
      if (pick < 56) begin
        r.target = servo_pos[r.ch];
      end else if (pick < 82) begin
        delta = $urandom_range(1, 6);
        if ($urandom_range(0, 1)) delta = -delta;
        r.target = servo_pos[r.ch] + delta;
        r.interval = $urandom_range(0, 5);
        if ($urandom_range(0, 19) == 0) begin
          // Long step interval, kept to a short ramp.
          r.target   = servo_pos[r.ch] + (delta > 0 ? 2 : -2);
          r.interval = $urandom_range(128, 255);
        end
      end else begin
        r.interval = $urandom_range(0, 2);
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input pwm_write_t want,
                               input pwm_write_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: expected ch %0d cmp %0d fin %0b rej %0b, got ch %0d cmp %0d fin %0b rej %0b",
               $realtime, what, want.ch, want.compare, want.final_write, want.rejected,
               got.ch, got.compare, got.final_write, got.rejected);
    end
  endtask

  // Offers one request after a random pause and updates the predictor once taken.
  task automatic send_request(input request_t r, input bit literal, input pwm_write_t want);
    int         gap;
    bit         has_write;
    pwm_write_t w;
    gap = idle_length();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.func     <= r.func;
    in_if.channel  <= r.ch;
    in_if.target   <= r.target;
    in_if.interval <= r.interval;
    do @(posedge clk); while (!in_if.ready);
    has_write = predict_request(r, w);
    if (literal) pending_writes.push_back(want);
    else if (has_write) pending_writes.push_back(w);
  endtask

  // Holds requests back until every write has arrived and the pipeline is empty.
  task automatic drain_block();
    in_if.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves valid high; the caller lowers it after the last write of a group.
  task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_CENTER:   cur_center   = data;
      CFG_GAIN:     cur_gain     = data[GAIN_W-1:0];
      CFG_POLARITY: cur_polarity = data[POL_W-1:0];
      default: ;
    endcase
  endtask

  // Result side: checks each write in order and stalls at random, with one
  // long hold-off on request so that the block backs up into its input.
  initial begin : result_sink
    int         stall_left;
    int         hold_left;
    pwm_write_t got;
    pwm_write_t want;
    stall_left = 0;
    hold_left  = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got = '{out_if.out_channel, out_if.compare, out_if.final_write, out_if.rejected};
        if (pending_writes.size() == 0) begin
          note_mismatch("unexpected compare write", NO_WRITE, got);
        end else begin
          want = pending_writes.pop_front();
          if (got.ch !== want.ch || got.compare !== want.compare ||
              got.final_write !== want.final_write || got.rejected !== want.rejected) begin
            note_mismatch("compare write mismatch", want, got);
          end
        end
      end
      if (hold_off_req) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        stall_left = idle_length();
        out_if.ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Request side: reset, directed script, then random phases between register writes.
  initial begin : stimulus
    request_t r;
    bit       counts;
    int       counted;
    mismatch_count = 0;
    quiet          = 1'b0;
    hold_off_req   = 1'b0;
    reset_predictor();
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.func     <= FUNC_TICK;
    in_if.channel  <= '0;
    in_if.target   <= '0;
    in_if.interval <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.index   <= CFG_CENTER;
    cfg_if.data    <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_SCRIPT[i]) begin
      send_request(DIRECTED_SCRIPT[i].req, DIRECTED_SCRIPT[i].literal, DIRECTED_SCRIPT[i].want);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        drain_block();
        case (phase)
          1: begin
            write_register(CFG_CENTER, 16'd0);
            write_register(CFG_GAIN, 16'd255);
            write_register(CFG_POLARITY, 16'd0);
          end
          2: begin
            write_register(CFG_CENTER, 16'd65535);
            write_register(CFG_GAIN, 16'd255);
            write_register(CFG_POLARITY, 16'h003F);
          end
          3: begin
            write_register(CFG_CENTER, 16'd3010);
            write_register(CFG_GAIN, 16'd0);
            write_register(CFG_POLARITY, $urandom_range(0, 63));
          end
          4: begin
            write_register(CFG_CENTER, $urandom_range(0, 65535));
            write_register(CFG_GAIN, $urandom_range(0, 65535));
            write_register(CFG_POLARITY, $urandom_range(0, 65535));
          end
          default: begin
            write_register(CFG_CENTER, 16'd32768);
            write_register(CFG_GAIN, 16'd1);
            write_register(CFG_POLARITY, 16'h002A);
          end
        endcase
        cfg_if.valid <= 1'b0;
      end
      // One phase runs without pauses; the second opens with the long hold-off.
      quiet = (phase == 3);
      if (phase == 1) hold_off_req = 1'b1;
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        r = random_request(counts);
        send_request(r, 1'b0, NO_WRITE);
        if (counts) counted++;
      end
    end

    drain_block();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
